@@ rtl/core/udht_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the ultrasonic distance hysteresis tracker.
// No dependencies; the echo, filter and top-level files import this package.
package udht_pkg;

    // Field widths
    localparam int DIST_W  = 10;
    localparam int STAMP_W = 16;
    localparam int LIMIT_W = 5;
    localparam int COUNT_W = 6;
    localparam int QUOT_W  = 11;

    // Divide by 58 as multiply by ceil(2^22 / 58) and shift; exact for 16-bit spans
    localparam int            ECHO_RECIP_W = 17;
    localparam logic [16:0]   ECHO_RECIP   = 17'd72316;
    localparam int            ECHO_SHIFT   = 22;

    // Divide by 10 as multiply by ceil(2^11 / 10) and shift; exact for 10-bit values
    localparam int            TEN_RECIP_W = 8;
    localparam logic [7:0]    TEN_RECIP   = 8'd205;
    localparam int            TEN_SHIFT   = 11;
    localparam int            TENTH_W     = DIST_W + TEN_RECIP_W - TEN_SHIFT;

    // Band offset added to held/10
    localparam logic [QUOT_W-1:0] BAND_OFFSET = 11'd5;

    // Persistence counter saturation bounds and unit step
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 6'sd31;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = -6'sd32;
    localparam logic signed [COUNT_W-1:0] COUNT_ONE = 6'sd1;

    // Register reset values
    localparam logic [DIST_W-1:0]  MIN_DIST_RST  = 10'd2;
    localparam logic [DIST_W-1:0]  MAX_DIST_RST  = 10'd400;
    localparam logic [LIMIT_W-1:0] LIMIT_RST     = 5'd20;
    localparam logic [DIST_W-1:0]  SNAP_RST      = 10'd360;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_DIST      = 2'd0,
        CFG_MAX_DIST      = 2'd1,
        CFG_PERSIST_LIMIT = 2'd2,
        CFG_SNAP_LEVEL    = 2'd3
    } cfg_index_t;

    // Input word kinds
    typedef enum logic {
        KIND_EDGE = 1'b0,
        KIND_TICK = 1'b1
    } item_kind_t;

    // Configuration bundle handed to the datapath parts
    typedef struct packed {
        logic [DIST_W-1:0]  min_distance;
        logic [DIST_W-1:0]  max_distance;
        logic [LIMIT_W-1:0] persistence_limit;
        logic [DIST_W-1:0]  snap_level;
    } udht_cfg_t;

endpackage

@@ rtl/core/udht_item_if.sv @@
`timescale 1ns / 1ps
// Input channel: valid/ready handshake carrying one echo edge or filter tick word.
// Standalone interface; widths match udht_pkg field widths.
interface udht_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] timestamp;

    modport source (output valid, output kind, output timestamp, input ready);
    modport sink   (input valid, input kind, input timestamp, output ready);
endinterface

@@ rtl/core/udht_result_if.sv @@
`timescale 1ns / 1ps
// Output channel: valid/ready handshake carrying held and raw distance.
// Standalone interface; widths match udht_pkg field widths.
interface udht_result_if;
    logic       valid;
    logic       ready;
    logic [9:0] held_distance;
    logic [9:0] raw_distance;

    modport source (output valid, output held_distance, output raw_distance, input ready);
    modport sink   (input valid, input held_distance, input raw_distance, output ready);
endinterface

@@ rtl/core/udht_echo.sv @@
`timescale 1ns / 1ps
// Echo timing: rising/falling edge pairing, span divide by 58 and clamp.
// Depends on udht_pkg.
module udht_echo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  logic [15:0]                     stamp,
    input  udht_pkg::udht_cfg_t             cfg,
    output logic [udht_pkg::DIST_W-1:0]     measured_next
);
    import udht_pkg::*;

    logic                         awaiting_fall_reg;
    logic                         awaiting_fall_next;
    logic [STAMP_W-1:0]           start_stamp_reg;
    logic [STAMP_W-1:0]           start_stamp_next;
    logic [DIST_W-1:0]            measured_reg;
    logic [STAMP_W-1:0]           span;
    logic [STAMP_W+ECHO_RECIP_W-1:0] product;
    logic [QUOT_W-1:0]            quot;
    logic [DIST_W-1:0]            clamped;

    // Wrapped span and reciprocal divide
    assign span    = stamp - start_stamp_reg;
    assign product = {{ECHO_RECIP_W{1'b0}}, span} * {{STAMP_W{1'b0}}, ECHO_RECIP};
    assign quot    = product[ECHO_SHIFT +: QUOT_W];

    // Clamp, upper bound tested first
    always_comb
    begin
        if (quot > {1'b0, cfg.max_distance})
        begin
            clamped = cfg.max_distance;
        end
        else if (quot < {1'b0, cfg.min_distance})
        begin
            clamped = cfg.min_distance;
        end
        else
        begin
            clamped = quot[DIST_W-1:0];
        end
    end

    // Rising edge stores the stamp, falling edge updates the reading
    always_comb
    begin
        awaiting_fall_next = awaiting_fall_reg;
        start_stamp_next   = start_stamp_reg;
        measured_next      = measured_reg;
        if (fire)
        begin
            awaiting_fall_next = !awaiting_fall_reg;
            if (awaiting_fall_reg)
            begin
                measured_next = clamped;
            end
            else
            begin
                start_stamp_next = stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_fall_reg <= 1'b0;
            start_stamp_reg   <= '0;
            measured_reg      <= '0;
        end
        else
        begin
            awaiting_fall_reg <= awaiting_fall_next;
            start_stamp_reg   <= start_stamp_next;
            measured_reg      <= measured_next;
        end
    end

`ifndef SYNTH
    // Each accepted edge flips the rising/falling expectation
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (awaiting_fall_reg != $past(awaiting_fall_reg)))
        else $error("echo edge did not toggle edge phase");
`endif

endmodule

@@ rtl/core/udht_filter.sv @@
`timescale 1ns / 1ps
// Hysteresis filter: band check, signed persistence counter, unit step and snap.
// Depends on udht_pkg.
module udht_filter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  logic [udht_pkg::DIST_W-1:0]     raw,
    input  udht_pkg::udht_cfg_t             cfg,
    output logic [udht_pkg::DIST_W-1:0]     held_next
);
    import udht_pkg::*;

    logic [DIST_W-1:0]                 held_reg;
    logic signed [COUNT_W-1:0]         count_reg;
    logic signed [COUNT_W-1:0]         count_next;
    logic [DIST_W+TEN_RECIP_W-1:0]     tenth_prod;
    logic [QUOT_W-1:0]                 band;
    logic [QUOT_W-1:0]                 held_ext;
    logic [QUOT_W-1:0]                 raw_ext;
    logic                              above;
    logic                              below;
    logic signed [COUNT_W:0]           count_wide;
    logic signed [COUNT_W:0]           limit_pos;
    logic signed [COUNT_W:0]           limit_neg;
    logic                              step;
    logic [DIST_W-1:0]                 held_step;
    logic signed [COUNT_W-1:0]         count_step;

    // Band = held/10 + 5
    assign tenth_prod = {{TEN_RECIP_W{1'b0}}, held_reg} * {{DIST_W{1'b0}}, TEN_RECIP};
    assign band       = {{(QUOT_W-TENTH_W){1'b0}}, tenth_prod[TEN_SHIFT +: TENTH_W]}
                        + BAND_OFFSET;
    assign held_ext   = {1'b0, held_reg};
    assign raw_ext    = {1'b0, raw};
    assign above      = raw_ext >= (held_ext + band);
    assign below      = (raw_ext + band) <= held_ext;

    assign count_wide = {count_reg[COUNT_W-1], count_reg};
    assign limit_pos  = $signed({{(COUNT_W+1-LIMIT_W){1'b0}}, cfg.persistence_limit});
    assign limit_neg  = -limit_pos;

    // Count out-of-band ticks, step once the limit is passed
    always_comb
    begin
        held_step  = held_reg;
        count_step = count_reg;
        step       = 1'b0;
        if (above)
        begin
            if (count_wide > limit_pos)
            begin
                held_step  = held_reg + 1'b1;
                count_step = '0;
                step       = 1'b1;
            end
            else if (count_reg != COUNT_MAX)
            begin
                count_step = count_reg + COUNT_ONE;
            end
        end
        else if (below)
        begin
            if (count_wide < limit_neg)
            begin
                held_step  = held_reg - 1'b1;
                count_step = '0;
                step       = 1'b1;
            end
            else if (count_reg != COUNT_MIN)
            begin
                count_step = count_reg - COUNT_ONE;
            end
        end
    end

    // Snap to a higher reading at the snap level; hold when no tick
    always_comb
    begin
        held_next  = held_reg;
        count_next = count_reg;
        if (fire)
        begin
            count_next = count_step;
            if ((held_step == cfg.snap_level) && (raw >= held_step))
            begin
                held_next = raw;
            end
            else
            begin
                held_next = held_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    // A held step always restarts the persistence count
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && step) |=> (count_reg == '0))
        else $error("persistence count not cleared after held step");
`endif

endmodule

@@ rtl/core/ultrasonic_distance_hysteresis_tracker.sv @@
`timescale 1ns / 1ps
// Ultrasonic distance tracker with hysteresis filter. Accepts one word per clock
// while the result side is not stalled and returns exactly one result word for
// each: an input register feeds the echo and filter update logic, whose state
// updates as the result register loads the held and raw distance after that word.
// Sustained rate is one word per cycle while the result side drains; the input and
// result registers let a new word enter while a finished result waits.
// Configuration is written through cfg_we/cfg_index/cfg_data while the block is
// idle; the user must keep to this, the block does not enforce it. Depends on
// udht_pkg, udht_item_if, udht_result_if, udht_echo and udht_filter.
module ultrasonic_distance_hysteresis_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    udht_item_if.sink                       item,
    udht_result_if.source                   result,
    input  logic                            cfg_we,
    input  udht_pkg::cfg_index_t            cfg_index,
    input  logic [udht_pkg::DIST_W-1:0]     cfg_data
);
    import udht_pkg::*;

    udht_cfg_t              cfg_reg;
    udht_cfg_t              cfg_next;
    logic                   stage_valid_reg;
    logic                   stage_valid_next;
    logic                   stage_kind_reg;
    logic [STAMP_W-1:0]     stage_stamp_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [DIST_W-1:0]      out_held_reg;
    logic [DIST_W-1:0]      out_raw_reg;
    logic                   advance;
    logic                   item_fire;
    logic                   stage_fire;
    logic                   edge_fire;
    logic                   tick_fire;
    logic [DIST_W-1:0]      measured_next;
    logic [DIST_W-1:0]      held_next;

    // Handshake control
    assign advance    = !out_valid_reg || result.ready;
    assign item.ready = !stage_valid_reg || advance;
    assign item_fire  = item.valid && item.ready;
    assign stage_fire = stage_valid_reg && advance;
    assign edge_fire  = stage_fire && (stage_kind_reg == KIND_EDGE);
    assign tick_fire  = stage_fire && (stage_kind_reg == KIND_TICK);

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_DIST:      cfg_next.min_distance      = cfg_data;
                CFG_MAX_DIST:      cfg_next.max_distance      = cfg_data;
                CFG_PERSIST_LIMIT: cfg_next.persistence_limit = cfg_data[LIMIT_W-1:0];
                CFG_SNAP_LEVEL:    cfg_next.snap_level        = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Advance valid flags of input and result registers
    always_comb
    begin
        if (item_fire)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_fire)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end

        if (stage_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_distance      <= MIN_DIST_RST;
            cfg_reg.max_distance      <= MAX_DIST_RST;
            cfg_reg.persistence_limit <= LIMIT_RST;
            cfg_reg.snap_level        <= SNAP_RST;
            stage_valid_reg           <= 1'b0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            cfg_reg         <= cfg_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            stage_kind_reg  <= item.kind;
            stage_stamp_reg <= item.timestamp;
        end
        if (stage_fire)
        begin
            out_held_reg <= held_next;
            out_raw_reg  <= measured_next;
        end
    end

    udht_echo u_echo (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (edge_fire),
        .stamp         (stage_stamp_reg),
        .cfg           (cfg_reg),
        .measured_next (measured_next)
    );

    udht_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (tick_fire),
        .raw       (measured_next),
        .cfg       (cfg_reg),
        .held_next (held_next)
    );

    assign result.valid         = out_valid_reg;
    assign result.held_distance = out_held_reg;
    assign result.raw_distance  = out_raw_reg;

`ifndef SYNTH
    // A new result only appears after a word sat in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(stage_valid_reg))
        else $error("result raised without a staged word");

    // A stalled staged word stays put until the result side drains
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=>
            (stage_valid_reg && $stable(stage_kind_reg) && $stable(stage_stamp_reg)))
        else $error("staged word lost during result stall");
`endif

endmodule
